FILE: hw/rtl/bts_pkg.sv
package bts_pkg;

   // Event codes carried in the func field
   localparam logic [2:0] FUNC_BEGIN    = 3'd0;
   localparam logic [2:0] FUNC_CHUNK    = 3'd1;
   localparam logic [2:0] FUNC_COMPLETE = 3'd2;
   localparam logic [2:0] FUNC_CLEAR    = 3'd3;
   localparam logic [2:0] FUNC_TAKE     = 3'd4;
   localparam logic [2:0] FUNC_READY    = 3'd5;
   localparam logic [2:0] FUNC_RESERVED = 3'd6;

   // Outcome codes
   localparam logic [1:0] OUT_OK    = 2'd0;
   localparam logic [1:0] OUT_RETRY = 2'd1;
   localparam logic [1:0] OUT_ERROR = 2'd2;

   // Backend completion codes
   localparam logic [2:0] CC_OK        = 3'd0;
   localparam logic [2:0] CC_NOT_READY = 3'd1;
   localparam logic [2:0] CC_RANGE     = 3'd2;
   localparam logic [2:0] CC_INVALID   = 3'd3;
   localparam logic [2:0] CC_OTHER     = 3'd4;

   // Sense keys and additional sense codes
   localparam logic [3:0] KEY_NOT_READY = 4'd2;
   localparam logic [3:0] KEY_MEDIUM    = 4'd3;
   localparam logic [3:0] KEY_ILLEGAL   = 4'd5;
   localparam logic [3:0] KEY_ATTENTION = 4'd6;

   localparam logic [7:0] ASC_NO_MEDIUM   = 8'h3a;
   localparam logic [7:0] ASC_LBA_RANGE   = 8'h21;
   localparam logic [7:0] ASC_INVALID_CDB = 8'h24;
   localparam logic [7:0] ASC_BAD_LUN     = 8'h25;
   localparam logic [7:0] ASC_CHANGED     = 8'h28;
   localparam logic [7:0] ASC_WRITE_ERR   = 8'h0c;
   localparam logic [7:0] ASC_READ_ERR    = 8'h11;

   localparam logic [15:0] SECTOR_BYTES = 16'd512;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  lun;
      logic        is_write;
      logic [31:0] lba;
      logic [31:0] byte_count;
      logic [31:0] chunk_offset;
      logic [15:0] sector_size;
      logic        medium_unlocked;
      logic [31:0] medium_sectors;
      logic [31:0] medium_generation;
      logic [2:0]  completion_code;
      logic        backend_accepts;
   } bts_req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [15:0] done_bytes;
      logic        sense_valid;
      logic [3:0]  sense_key;
      logic [7:0]  sense_code;
      logic        request_valid;
      logic        request_write;
      logic [31:0] request_lba;
      logic [6:0]  request_sectors;
      logic [31:0] read_total;
      logic [31:0] write_total;
   } bts_rsp_type;

   // Command pipeline state, updated once per item
   typedef struct packed {
      logic        active;
      logic        dir_write;
      logic [31:0] next_sector;
      logic [31:0] bytes_left;
      logic        in_flight;
      logic        result_ready;
      logic        last_write_wait;
      logic [15:0] in_flight_bytes;
      logic [2:0]  held_code;
      logic        held_unlocked;
      logic [31:0] seen_generation;
      logic [31:0] read_count;
      logic [31:0] write_count;
   } bts_state_type;

   typedef struct packed {
      logic [3:0] key;
      logic [7:0] code;
   } bts_sense_type;

   // Map a backend status code to sense key and additional code
   function automatic bts_sense_type sense_for(logic [2:0] code, logic wr);
      bts_sense_type s;
      case (code)
         CC_NOT_READY: s = '{key: KEY_NOT_READY, code: ASC_NO_MEDIUM};
         CC_RANGE:     s = '{key: KEY_ILLEGAL, code: ASC_LBA_RANGE};
         CC_INVALID:   s = '{key: KEY_ILLEGAL, code: ASC_INVALID_CDB};
         default:      s = '{key: KEY_MEDIUM, code: (wr ? ASC_WRITE_ERR : ASC_READ_ERR)};
      endcase
      return s;
   endfunction

endpackage

FILE: hw/rtl/bts_step.sv
module bts_step
   import bts_pkg::*;
#(
   parameter int BATCH_BYTES = 4096
) (
   input  bts_state_type cur,
   input  bts_req_type   item,
   output bts_state_type nxt,
   output bts_rsp_type   rsp
);

   localparam logic [31:0] BatchBytes = 32'(BATCH_BYTES);

   logic          bytes_ok;
   logic [32:0]   chunk_sector;
   logic          chunk_pos_bad;
   logic [31:0]   chunk_secs;
   logic [31:0]   left_after;
   logic [31:0]   sector_after;
   logic [31:0]   next_batch;
   logic [31:0]   room;
   bts_sense_type snd;

   // Shared chunk checks and arithmetic
   always_comb begin
      bytes_ok = (item.byte_count != 32'd0) && (item.byte_count <= BatchBytes) &&
                 (item.byte_count[8:0] == 9'd0) && (item.chunk_offset[8:0] == 9'd0);
      chunk_sector  = {1'b0, item.lba} + {10'd0, item.chunk_offset[31:9]};
      chunk_pos_bad = chunk_sector[32] || (chunk_sector[31:0] != cur.next_sector) ||
                      (item.byte_count > cur.bytes_left);
      chunk_secs    = {9'd0, item.byte_count[31:9]};
      left_after    = cur.bytes_left - item.byte_count;
      sector_after  = cur.next_sector + chunk_secs;
      next_batch    = (left_after < BatchBytes) ? left_after : BatchBytes;
      room          = item.medium_sectors - item.lba;
   end

   // Per-item state update and result
   always_comb begin
      nxt = cur;
      rsp = '0;
      snd = '0;
      case (item.func)
         FUNC_BEGIN: begin
            nxt.active          = 1'b0;
            nxt.in_flight       = 1'b0;
            nxt.result_ready    = 1'b0;
            nxt.last_write_wait = 1'b0;
            rsp.outcome         = OUT_RETRY;
            rsp.sense_valid     = 1'b1;
            if (item.lun != 8'd0) begin
               snd = '{key: KEY_ILLEGAL, code: ASC_BAD_LUN};
            end else if (item.sector_size != SECTOR_BYTES || item.byte_count == 32'd0 ||
                         item.byte_count[8:0] != 9'd0) begin
               snd = sense_for(CC_INVALID, item.is_write);
            end else if (!item.medium_unlocked || item.medium_sectors == 32'd0) begin
               snd = '{key: KEY_NOT_READY, code: ASC_NO_MEDIUM};
            end else if (item.lba >= item.medium_sectors || chunk_secs > room) begin
               snd = sense_for(CC_RANGE, item.is_write);
            end else begin
               rsp.sense_valid = 1'b0;
               rsp.outcome     = OUT_OK;
               nxt.active      = 1'b1;
               nxt.dir_write   = item.is_write;
               nxt.next_sector = item.lba;
               nxt.bytes_left  = item.byte_count;
            end
         end
         FUNC_CHUNK: begin
            if (item.lun != 8'd0) begin
               rsp.outcome     = OUT_ERROR;
               rsp.sense_valid = 1'b1;
               snd = '{key: KEY_ILLEGAL, code: ASC_BAD_LUN};
            end else if (!bytes_ok) begin
               rsp.outcome     = OUT_ERROR;
               rsp.sense_valid = 1'b1;
               snd = sense_for(CC_INVALID, item.is_write);
            end else if (!cur.active || cur.dir_write != item.is_write) begin
               rsp.outcome     = OUT_ERROR;
               rsp.sense_valid = 1'b1;
               snd = sense_for(CC_NOT_READY, item.is_write);
            end else if (chunk_pos_bad) begin
               rsp.outcome     = OUT_ERROR;
               rsp.sense_valid = 1'b1;
               snd = sense_for(CC_INVALID, item.is_write);
            end else if (cur.in_flight) begin
               rsp.outcome = OUT_RETRY;
            end else if (cur.result_ready && (cur.held_code != CC_OK || !cur.held_unlocked)) begin
               // Failed batch: drop the command and report the held status
               nxt.active          = 1'b0;
               nxt.in_flight       = 1'b0;
               nxt.result_ready    = 1'b0;
               nxt.last_write_wait = 1'b0;
               rsp.outcome         = OUT_ERROR;
               rsp.sense_valid     = 1'b1;
               snd = sense_for((cur.held_code != CC_OK) ? cur.held_code : CC_NOT_READY,
                               item.is_write);
            end else if (item.is_write) begin
               nxt.result_ready = 1'b0;
               if (cur.last_write_wait) begin
                  // Final write has completed: finish the command
                  nxt.last_write_wait = 1'b0;
                  nxt.active          = 1'b0;
                  rsp.done_bytes      = item.byte_count[15:0];
               end else if (!item.backend_accepts) begin
                  rsp.outcome = OUT_RETRY;
               end else begin
                  rsp.request_valid   = 1'b1;
                  rsp.request_write   = 1'b1;
                  rsp.request_lba     = cur.next_sector;
                  rsp.request_sectors = item.byte_count[15:9];
                  nxt.in_flight_bytes = item.byte_count[15:0];
                  nxt.in_flight       = 1'b1;
                  if (item.byte_count == cur.bytes_left) begin
                     nxt.last_write_wait = 1'b1;
                     rsp.outcome         = OUT_RETRY;
                  end else begin
                     nxt.bytes_left  = left_after;
                     nxt.next_sector = sector_after;
                     rsp.done_bytes  = item.byte_count[15:0];
                  end
               end
            end else if (!cur.result_ready) begin
               // Read with nothing fetched yet: start the fetch
               rsp.outcome = OUT_RETRY;
               if (item.backend_accepts) begin
                  rsp.request_valid   = 1'b1;
                  rsp.request_lba     = cur.next_sector;
                  rsp.request_sectors = item.byte_count[15:9];
                  nxt.in_flight_bytes = item.byte_count[15:0];
                  nxt.in_flight       = 1'b1;
               end
            end else begin
               // Read data delivered; prefetch the next batch, or finish the command if none is left
               nxt.result_ready = 1'b0;
               nxt.bytes_left   = left_after;
               nxt.next_sector  = sector_after;
               nxt.read_count   = cur.read_count + item.byte_count;
               rsp.done_bytes   = item.byte_count[15:0];
               if (left_after != 32'd0) begin
                  if (item.backend_accepts) begin
                     rsp.request_valid   = 1'b1;
                     rsp.request_lba     = sector_after;
                     rsp.request_sectors = next_batch[15:9];
                     nxt.in_flight_bytes = next_batch[15:0];
                     nxt.in_flight       = 1'b1;
                  end
               end else begin
                  nxt.active = 1'b0;
               end
            end
         end
         FUNC_COMPLETE: begin
            if (cur.in_flight) begin
               nxt.in_flight     = 1'b0;
               nxt.result_ready  = 1'b1;
               nxt.held_code     = item.completion_code;
               nxt.held_unlocked = item.medium_unlocked;
               if (cur.dir_write && item.completion_code == CC_OK && item.medium_unlocked) begin
                  nxt.write_count = cur.write_count + {16'd0, cur.in_flight_bytes};
               end
            end
         end
         FUNC_CLEAR: begin
            nxt.active          = 1'b0;
            nxt.in_flight       = 1'b0;
            nxt.result_ready    = 1'b0;
            nxt.last_write_wait = 1'b0;
         end
         FUNC_TAKE: begin
            rsp.read_total  = cur.read_count;
            rsp.write_total = cur.write_count;
            nxt.read_count  = '0;
            nxt.write_count = '0;
         end
         FUNC_READY: begin
            rsp.outcome     = OUT_RETRY;
            rsp.sense_valid = 1'b1;
            if (item.lun != 8'd0) begin
               snd = '{key: KEY_ILLEGAL, code: ASC_BAD_LUN};
            end else if (!item.medium_unlocked || item.medium_sectors == 32'd0) begin
               nxt.seen_generation = item.medium_generation;
               snd = '{key: KEY_NOT_READY, code: ASC_NO_MEDIUM};
            end else if (cur.seen_generation != item.medium_generation) begin
               nxt.seen_generation = item.medium_generation;
               snd = '{key: KEY_ATTENTION, code: ASC_CHANGED};
            end else begin
               rsp.sense_valid = 1'b0;
               rsp.outcome     = OUT_OK;
            end
         end
         default: begin
            rsp.outcome = OUT_ERROR;
         end
      endcase
      if (rsp.sense_valid) begin
         rsp.sense_key  = snd.key;
         rsp.sense_code = snd.code;
      end
   end

endmodule

FILE: hw/rtl/block_transfer_sequencer_top.sv
// Channel   Direction  Ports                                Payload
// req       in         req_valid, req_ready, req_data       bts_req_type
// rsp       out        rsp_valid, rsp_ready, rsp_data       bts_rsp_type
//
// One item per cycle sustained while rsp_ready is high; each item passes the
// input register and then the result register, where its result is valid.
// Command state updates as the item moves into the result register, so items
// are handled strictly in order through a single step of logic.
// A stalled result holds the input register; req_ready drops only then.
// Reset (synchronous) clears both valid flags and all command state.
module block_transfer_sequencer_top
   import bts_pkg::*;
#(
   parameter int BATCH_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bts_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bts_rsp_type rsp_data
);

   logic          in_valid_ff, in_valid_in;
   bts_req_type   in_item_ff;
   logic          out_valid_ff, out_valid_in;
   bts_rsp_type   out_item_ff;
   bts_state_type state_ff, state_in;
   bts_rsp_type   step_rsp;
   logic          advance;

   // Item moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   bts_step #(
      .BATCH_BYTES(BATCH_BYTES)
   ) u_step (
      .cur (state_ff),
      .item(in_item_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   always_comb begin
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // A batch in flight and a held completion never coexist
   a_flight_excl: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.in_flight && state_ff.result_ready))
      else $error("in_flight and result_ready both set");

   // Waiting on the final write only within an active write command
   a_last_write: assert property (@(posedge clock) disable iff (reset)
      state_ff.last_write_wait |-> (state_ff.active && state_ff.dir_write))
      else $error("last_write_wait outside active write");

   // An issued batch never comes with an error outcome
   a_req_no_err: assert property (@(posedge clock) disable iff (reset)
      (advance && step_rsp.request_valid) |=> (rsp_data.outcome != OUT_ERROR))
      else $error("batch issued with error outcome");

   // Completed bytes only on success
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_bytes != 16'd0) |-> (rsp_data.outcome == OUT_OK))
      else $error("done_bytes on non-success");

endmodule
